// File: sv/wve_pkg.sv
// Package for the windowed velocity estimator.
// Holds the transaction types, widths, register codes, reset values and sequencer states.
// No dependencies.
package wve_pkg;

    localparam int WINDOW_DEF = 5;
    localparam int DATA_W     = 32;
    localparam int FALLBACK_W = 20;
    localparam int PADDR_W    = 3;
    localparam int US_W       = 20;
    localparam int MAG_W      = DATA_W + 1;
    localparam int PROD_W     = 52;

    localparam logic [US_W-1:0]       US_PER_S       = 20'd1000000;
    localparam logic [FALLBACK_W-1:0] FALLBACK_RST   = 20'd1000;
    localparam logic [DATA_W-1:0]     MAX_PERIOD_RST = 32'd500000;
    localparam logic [DATA_W-1:0]     VEL_MAX        = 32'h7FFF_FFFF;
    localparam logic [DATA_W-1:0]     VEL_MIN        = 32'h8000_0000;

    typedef enum logic [0:0] {
        REG_FALLBACK   = 1'b0,
        REG_MAX_PERIOD = 1'b1
    } t_reg_idx;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CALC,
        ST_ABS,
        ST_MUL,
        ST_DIV,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic signed [DATA_W-1:0] angle_sample;
        logic        [DATA_W-1:0] time_us;
    } t_in;

    typedef struct packed {
        logic signed [DATA_W-1:0] velocity;
        logic                     ready_res;
        logic                     used_fallback;
        logic                     saturated;
    } t_out;

    typedef struct packed {
        logic [DATA_W-1:0] newest_angle;
        logic [DATA_W-1:0] newest_time;
        logic [DATA_W-1:0] oldest_angle;
        logic [DATA_W-1:0] oldest_time;
        logic              two_held;
    } t_hist_view;

endpackage

// File: sv/wve_history.sv
// Sample history of the windowed velocity estimator: a shift line of angle and time
// samples with a saturating fill count. Depends on wve_pkg.
module wve_history #(
    parameter int WINDOW = wve_pkg::WINDOW_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  wve_pkg::t_in        i_sample,
    output wve_pkg::t_hist_view o_view
);
    import wve_pkg::*;

    localparam int FW = $clog2(WINDOW + 1);
    localparam int IW = $clog2(WINDOW);

    logic [DATA_W-1:0] r_angle [WINDOW];
    logic [DATA_W-1:0] r_time  [WINDOW];
    logic [FW-1:0]     r_fill;
    logic [FW-1:0]     oldest_full;
    logic [IW-1:0]     oldest_idx;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_angle[0] <= i_sample.angle_sample;
            r_time[0]  <= i_sample.time_us;
            for (int k = 1; k < WINDOW; k++) begin
                r_angle[k] <= r_angle[k-1];
                r_time[k]  <= r_time[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
        end else if (i_push && (r_fill != FW'(WINDOW))) begin
            r_fill <= r_fill + 1'b1;
        end
    end

    always_comb begin
        oldest_full         = r_fill - 1'b1;
        oldest_idx          = oldest_full[IW-1:0];
        o_view.newest_angle = r_angle[0];
        o_view.newest_time  = r_time[0];
        o_view.oldest_angle = r_angle[oldest_idx];
        o_view.oldest_time  = r_time[oldest_idx];
        o_view.two_held     = (r_fill >= FW'(2));
    end

endmodule

// File: sv/wve_div.sv
// Restoring divider of the windowed velocity estimator, one quotient bit per cycle.
// Depends on wve_pkg only through the default widths.
module wve_div #(
    parameter int DVD_W = wve_pkg::PROD_W,
    parameter int DVS_W = wve_pkg::DATA_W
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [DVD_W-1:0] i_dividend,
    input  logic [DVS_W-1:0] i_divisor,
    output logic             o_done,
    output logic [DVD_W-1:0] o_quotient
);
    localparam int CW = $clog2(DVD_W + 1);

    logic [DVS_W-1:0] r_rem;
    logic [DVS_W-1:0] r_dvs;
    logic [DVD_W-1:0] r_quo;
    logic [CW-1:0]    r_cnt;
    logic             r_busy;
    logic             r_done;
    logic [DVS_W:0]   trial;
    logic [DVS_W:0]   diff;
    logic             take;

    always_comb begin
        trial = {r_rem, r_quo[DVD_W-1]};
        diff  = trial - {1'b0, r_dvs};
        take  = (trial >= {1'b0, r_dvs});
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_dvs <= i_divisor;
            r_quo <= i_dividend;
        end else if (r_busy) begin
            r_rem <= take ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
            r_quo <= {r_quo[DVD_W-2:0], take};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= CW'(DVD_W);
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == CW'(1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end else begin
            r_done <= 1'b0;
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

// File: sv/windowed_velocity_estimator.sv
// Top level of the windowed velocity estimator: handshake, APB registers and sequencer.
// Depends on wve_pkg, wve_history and wve_div.
//
// Each accepted sample is pushed into a window of the last WINDOW samples. The velocity is
// the angle change from the oldest to the newest held sample, times one million, divided by
// their time span in microseconds (the fallback period when the span is zero or above the
// maximum), in signed Q15.16 rad/s with saturation. An item passes the CALC, ABS, MUL, DIV
// and DONE states, waiting in DIV on the 52-step serial divider; with fewer than two samples
// held, CALC goes straight to DONE. DONE loads the result once the output register is free.
// The block takes one item at a time, and the input is ready again once the result is in the
// output register.
module windowed_velocity_estimator #(
    parameter int WINDOW = wve_pkg::WINDOW_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  wve_pkg::t_in                  i_in_data,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output wve_pkg::t_out                 o_out_data,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [wve_pkg::PADDR_W-1:0]   paddr,
    input  logic [wve_pkg::DATA_W-1:0]    pwdata,
    output logic [wve_pkg::DATA_W-1:0]    prdata,
    output logic                          pready
);
    import wve_pkg::*;

    t_state            r_state;
    t_state            n_state;
    logic [FALLBACK_W-1:0] r_fallback_period;
    logic [DATA_W-1:0] r_max_period;
    t_reg_idx          reg_idx;

    t_hist_view        view;
    logic              push;

    logic [DATA_W-1:0] span;
    logic              use_fb;
    logic [DATA_W-1:0] period;
    logic [MAG_W-1:0]  diff;

    logic [MAG_W-1:0]  r_diff;
    logic [MAG_W-1:0]  r_mag;
    logic [DATA_W-1:0] r_period;
    logic              r_neg;
    logic              r_fb;
    logic              r_ready_res;

    logic [MAG_W+US_W-1:0] product;
    logic              div_start;
    logic              div_done;
    logic [PROD_W-1:0] quotient;

    logic              out_load;
    t_out              res;
    t_out              r_out;
    logic              r_out_valid;

    assign reg_idx = t_reg_idx'(paddr[2]);
    assign pready  = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fallback_period <= FALLBACK_RST;
            r_max_period      <= MAX_PERIOD_RST;
        end else if (psel && penable && pwrite) begin
            unique case (reg_idx)
                REG_FALLBACK:   r_fallback_period <= pwdata[FALLBACK_W-1:0];
                REG_MAX_PERIOD: r_max_period      <= pwdata;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_FALLBACK:   prdata = {{(DATA_W-FALLBACK_W){1'b0}}, r_fallback_period};
            REG_MAX_PERIOD: prdata = r_max_period;
        endcase
    end

    assign push = i_in_valid && o_in_ready;

    wve_history #(
        .WINDOW(WINDOW)
    ) u_history (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_sample (i_in_data),
        .o_view   (view)
    );

    always_comb begin
        span   = view.newest_time - view.oldest_time;
        use_fb = (span == '0) || (span > r_max_period);
        period = use_fb ? {{(DATA_W-FALLBACK_W){1'b0}}, r_fallback_period} : span;
        if (period == '0) begin
            period = DATA_W'(1);
        end
        diff = {view.newest_angle[DATA_W-1], view.newest_angle}
             - {view.oldest_angle[DATA_W-1], view.oldest_angle};
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_CALC) begin
            r_diff      <= diff;
            r_period    <= period;
            r_fb        <= use_fb;
            r_ready_res <= view.two_held;
        end
        if (r_state == ST_ABS) begin
            r_neg <= r_diff[MAG_W-1];
            r_mag <= r_diff[MAG_W-1] ? (~r_diff + 1'b1) : r_diff;
        end
    end

    assign product   = r_mag * US_PER_S;
    assign div_start = (r_state == ST_MUL);

    wve_div #(
        .DVD_W(PROD_W),
        .DVS_W(DATA_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (product[PROD_W-1:0]),
        .i_divisor  (r_period),
        .o_done     (div_done),
        .o_quotient (quotient)
    );

    always_comb begin
        res = '0;
        if (r_ready_res) begin
            res.ready_res     = 1'b1;
            res.used_fallback = r_fb;
            if (r_neg) begin
                res.saturated = (quotient > PROD_W'(VEL_MIN));
                res.velocity  = res.saturated ? VEL_MIN : (~quotient[DATA_W-1:0] + 1'b1);
            end else begin
                res.saturated = (quotient > PROD_W'(VEL_MAX));
                res.velocity  = res.saturated ? VEL_MAX : quotient[DATA_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_in_ready = 1'b0;
        out_load   = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = i_rst_n;
                if (i_in_valid) begin
                    n_state = ST_CALC;
                end
            end
            ST_CALC: begin
                n_state = view.two_held ? ST_ABS : ST_DONE;
            end
            ST_ABS: begin
                n_state = ST_MUL;
            end
            ST_MUL: begin
                n_state = ST_DIV;
            end
            ST_DIV: begin
                if (div_done) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    out_load = 1'b1;
                    n_state  = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out <= res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

// File: sim/windowed_velocity_estimator_tb.sv
// Self-checking testbench for the windowed velocity estimator.
// Predicts every result from the sampled angle and time transactions and the register settings.
// Depends on wve_pkg and windowed_velocity_estimator.
module windowed_velocity_estimator_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import wve_pkg::*;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_in_valid;
    logic                o_in_ready;
    t_in                 i_in_data;
    logic                o_out_valid;
    logic                i_out_ready;
    t_out                o_out_data;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [PADDR_W-1:0]  paddr;
    logic [DATA_W-1:0]   pwdata;
    logic [DATA_W-1:0]   prdata;
    logic                pready;

    logic signed [DATA_W-1:0] hist_angle [WINDOW_DEF];
    logic [DATA_W-1:0]        hist_time [WINDOW_DEF];
    int unsigned              hist_fill;
    logic [FALLBACK_W-1:0]    cfg_fallback;
    logic [DATA_W-1:0]        cfg_max_period;

    t_out                     velocity_q [$];
    int                       failure_count;
    logic                     idle_off;
    logic [DATA_W-1:0]        gen_angle;
    logic [DATA_W-1:0]        gen_time;

    windowed_velocity_estimator dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    always begin
        i_clk = 1'b1;
        #6;
        i_clk = 1'b0;
        #6;
    end

    function automatic t_out estimate_velocity(input t_in s);
        t_out        r;
        int          k;
        int unsigned oldest;
        logic [31:0] span;
        longint      period;
        longint      diff;
        longint      mag;
        longint      quo;
        r = '0;
        for (k = WINDOW_DEF - 1; k > 0; k--) begin
            hist_angle[k] = hist_angle[k-1];
            hist_time[k]  = hist_time[k-1];
        end
        hist_angle[0] = s.angle_sample;
        hist_time[0]  = s.time_us;
        if (hist_fill < WINDOW_DEF) begin
            hist_fill++;
        end
        if (hist_fill < 2) begin
            return r;
        end
        oldest = hist_fill - 1;
        span = hist_time[0] - hist_time[oldest];
        if (span == 0 || span > cfg_max_period) begin
            period = longint'(cfg_fallback);
            r.used_fallback = 1'b1;
        end else begin
            period = longint'(span);
        end
        if (period == 0) begin
            period = 1;
        end
        diff = longint'(hist_angle[0]) - longint'(hist_angle[oldest]);
        mag = (diff < 0) ? -diff : diff;
        quo = (mag * 1000000) / period;
        r.ready_res = 1'b1;
        if (diff < 0) begin
            if (quo > 64'sh8000_0000) begin
                quo = 64'sh8000_0000;
                r.saturated = 1'b1;
            end
            r.velocity = -quo[31:0];
        end else begin
            if (quo > 64'sh7FFF_FFFF) begin
                quo = 64'sh7FFF_FFFF;
                r.saturated = 1'b1;
            end
            r.velocity = quo[31:0];
        end
        return r;
    endfunction

    task automatic report_failure(input string msg);
        $display("ERROR at %0t ns: %s", $realtime, msg);
        failure_count++;
    endtask

    always @(posedge i_clk) begin : result_check
        t_out want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (velocity_q.size() == 0) begin
                report_failure("result transaction with no expectation pending");
            end else begin
                want = velocity_q.pop_front();
                if (o_out_data.velocity !== want.velocity) begin
                    report_failure($sformatf("velocity got %0d expected %0d",
                                             o_out_data.velocity, want.velocity));
                end
                if (o_out_data.ready_res !== want.ready_res) begin
                    report_failure($sformatf("ready_res got %b expected %b",
                                             o_out_data.ready_res, want.ready_res));
                end
                if (o_out_data.used_fallback !== want.used_fallback) begin
                    report_failure($sformatf("used_fallback got %b expected %b",
                                             o_out_data.used_fallback, want.used_fallback));
                end
                if (o_out_data.saturated !== want.saturated) begin
                    report_failure($sformatf("saturated got %b expected %b",
                                             o_out_data.saturated, want.saturated));
                end
            end
        end
    end

    always @(negedge i_clk) begin
        i_out_ready = idle_off || ($urandom_range(99) >= 6);
    end

    task automatic send_sample(input logic [31:0] angle, input logic [31:0] stamp);
        t_in item;
        int  gap;
        item.angle_sample = angle;
        item.time_us      = stamp;
        i_in_data  = item;
        i_in_valid = 1'b1;
        do @(posedge i_clk); while (!o_in_ready);
        velocity_q.push_back(estimate_velocity(item));
        @(negedge i_clk);
        if (!idle_off && $urandom_range(99) < 30) begin
            gap = $urandom_range(20, 1);
            i_in_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
    endtask

    task automatic wait_for_results();
        i_in_valid = 1'b0;
        while (velocity_q.size() != 0) @(negedge i_clk);
        repeat (2) @(negedge i_clk);
    endtask

    task automatic write_register(input t_reg_idx idx, input logic [31:0] value);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {idx, 2'b00};
        pwdata  = value;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        if (idx == REG_FALLBACK) begin
            cfg_fallback = value[FALLBACK_W-1:0];
        end else begin
            cfg_max_period = value;
        end
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task automatic next_sample();
        int delta;
        if ($urandom_range(99) < 10) begin
            gen_angle = $urandom;
            gen_time  = $urandom;
        end else begin
            case ($urandom_range(99)) inside
                [0:79]:  gen_time = gen_time + $urandom_range(3000, 1);
                [80:87]: gen_time = gen_time;
                [88:94]: gen_time = gen_time + $urandom_range(2000000, 400000);
                default: gen_time = gen_time + $urandom;
            endcase
            case ($urandom_range(99)) inside
                [0:59]:  delta = int'($urandom_range(2000)) - 1000;
                [60:84]: delta = int'($urandom_range(2097152)) - 1048576;
                default: delta = $urandom;
            endcase
            gen_angle = gen_angle + 32'(delta);
        end
        send_sample(gen_angle, gen_time);
    endtask

    task automatic test_warmup();
        send_sample(32'h0000_0000, 32'd0);
        send_sample(32'h0000_1000, 32'd1000);
    endtask

    task automatic test_angle_extremes();
        send_sample(32'h7FFF_FFFF, 32'd2000);
        send_sample(32'h8000_0000, 32'd3000);
        send_sample(32'hFFFF_FFFF, 32'd4000);
        send_sample(32'h7FFF_FFFF, 32'd5000);
        send_sample(32'h8000_0000, 32'd6000);
    endtask

    task automatic test_rounding();
        int k;
        for (k = 0; k < WINDOW_DEF; k++) begin
            send_sample(-32'(k), 32'd10000 + 32'(3 * k));
        end
    endtask

    task automatic test_time_wrap();
        send_sample(32'd100, 32'hFFFF_FFF0);
        send_sample(32'd200, 32'hFFFF_FFF8);
        send_sample(32'd300, 32'd4);
    endtask

    task automatic test_span_fallback();
        int k;
        for (k = 0; k < WINDOW_DEF; k++) begin
            send_sample(32'(k * 700), 32'd50000);
        end
        send_sample(32'd9000, 32'd650000);
    endtask

    task automatic test_register_extremes();
        int k;
        wait_for_results();
        write_register(REG_FALLBACK, 32'd0);
        for (k = 0; k < WINDOW_DEF; k++) begin
            send_sample(32'(k * 3), 32'd80000);
        end
        wait_for_results();
        write_register(REG_MAX_PERIOD, 32'd0);
        send_sample(32'd20, 32'd81000);
        wait_for_results();
        write_register(REG_FALLBACK, 32'd1000000);
        send_sample(32'h0100_0000, 32'd82000);
        wait_for_results();
        write_register(REG_MAX_PERIOD, 32'hFFFF_FFFF);
        write_register(REG_FALLBACK, 32'd1);
        send_sample(32'h8000_0000, 32'h8000_0000);
        send_sample(32'h7FFF_FFFF, 32'h0000_1000);
        wait_for_results();
        write_register(REG_MAX_PERIOD, 32'd1);
        send_sample(32'd5, 32'h0000_1001);
        send_sample(32'd6, 32'h0000_1002);
        wait_for_results();
        write_register(REG_FALLBACK, 32'(FALLBACK_RST));
        write_register(REG_MAX_PERIOD, MAX_PERIOD_RST);
    endtask

    task automatic test_random_phases(input int phases, input int per_phase);
        int p;
        int n;
        for (p = 0; p < phases; p++) begin
            wait_for_results();
            case ($urandom_range(5))
                0:       write_register(REG_FALLBACK, 32'd1);
                1:       write_register(REG_FALLBACK, 32'd1000000);
                2:       write_register(REG_FALLBACK, $urandom_range(1000000, 1));
                3:       write_register(REG_FALLBACK, $urandom_range(5000, 1));
                4:       write_register(REG_FALLBACK, 32'd0);
                default: write_register(REG_FALLBACK, 32'(FALLBACK_RST));
            endcase
            case ($urandom_range(6))
                0:       write_register(REG_MAX_PERIOD, 32'd1);
                1:       write_register(REG_MAX_PERIOD, 32'hFFFF_FFFF);
                2:       write_register(REG_MAX_PERIOD, $urandom_range(5000, 1));
                3:       write_register(REG_MAX_PERIOD, $urandom_range(2000000, 1000));
                4:       write_register(REG_MAX_PERIOD, $urandom);
                5:       write_register(REG_MAX_PERIOD, 32'd0);
                default: write_register(REG_MAX_PERIOD, MAX_PERIOD_RST);
            endcase
            for (n = 0; n < per_phase; n++) begin
                if ($urandom_range(99) < 3) begin
                    wait_for_results();
                end
                next_sample();
            end
        end
    endtask

    task automatic test_no_idle(input int count);
        int n;
        wait_for_results();
        idle_off = 1'b1;
        for (n = 0; n < count; n++) begin
            next_sample();
        end
        wait_for_results();
        idle_off = 1'b0;
    endtask

    initial begin
        int c;
        i_rst_n        = 1'b0;
        i_in_valid     = 1'b0;
        i_in_data      = '0;
        i_out_ready    = 1'b0;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;
        idle_off       = 1'b0;
        failure_count  = 0;
        hist_fill      = 0;
        cfg_fallback   = FALLBACK_RST;
        cfg_max_period = MAX_PERIOD_RST;
        gen_angle      = '0;
        gen_time       = '0;
        for (c = 0; c < WINDOW_DEF; c++) begin
            hist_angle[c] = '0;
            hist_time[c]  = '0;
        end
        repeat (8) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        test_warmup();
        test_angle_extremes();
        test_rounding();
        test_time_wrap();
        test_span_fallback();
        test_register_extremes();
        test_random_phases(10, 100);
        test_no_idle(120);

        i_in_valid = 1'b0;
        for (c = 0; c < 20000 && velocity_q.size() != 0; c++) begin
            @(negedge i_clk);
        end
        repeat (70) @(posedge i_clk);
        if (velocity_q.size() != 0) begin
            report_failure($sformatf("%0d expected results never arrived", velocity_q.size()));
        end
        if (failure_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    initial begin
        #(800000 * 12);
        $display("Simulation FAILED");
        $finish;
    end

endmodule
